FILE: design/audio_block_rms_db_meter_core_assert.svh
`ifndef AUDIO_BLOCK_RMS_DB_METER_CORE_ASSERT_SVH
`define AUDIO_BLOCK_RMS_DB_METER_CORE_ASSERT_SVH

// Condition that must hold at every clock edge outside reset
`define ABRM_ASSERT(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("abrm check failed");

// Condition in one cycle implies a condition in the next
`define ABRM_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("abrm sequence check failed");

`endif

FILE: design/abrm_pkg.sv
package abrm_pkg;

   localparam int MAX_BLOCK = 1024;
   localparam int SAMPLE_W  = 16;
   localparam int SUM_W     = 41;
   localparam int COUNT_W   = $clog2(MAX_BLOCK + 1);
   localparam int RMS_W     = 24;
   localparam int DB_W      = 16;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 1;

   // Dividend is sum << 16
   localparam int WORK_W    = SUM_W + 16;
   localparam int REM_W     = RMS_W + 1;
   localparam int SUB_W     = RMS_W + 4;
   localparam int MUL_W     = 33;
   localparam int MANT_W    = 31;
   localparam int FRAC_W    = 16;
   localparam int LOG_W     = 6 + FRAC_W;
   localparam int V_W       = 55;
   localparam int STEP_W    = 6;

   localparam logic [15:0] LN2_Q16 = 16'd45426;
   localparam logic [CSR_W-1:0] DB_GAIN_RESET   = 16'd2151;
   localparam logic [CSR_W-1:0] DB_OFFSET_RESET = 16'd5347;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DB_GAIN   = 1'b0,
      CSR_DB_OFFSET = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_SQRT,
      ST_NORM,
      ST_LOGSQ,
      ST_GAIN,
      ST_SCALE,
      ST_FINISH,
      ST_DONE
   } state_type;

   // Finished block handed to the post-processing sequencer
   typedef struct packed {
      logic [SUM_W-1:0]   sum;
      logic [COUNT_W-1:0] count;
   } blk_type;

   typedef struct packed {
      logic [RMS_W-1:0]       rms;
      logic signed [DB_W-1:0] db;
      logic                   silent;
   } res_type;

endpackage

FILE: design/audio_block_rms_db_meter_core.sv
// Block RMS level meter. Each accepted sample has its square added to a 41-bit sum and
// is counted. The sample marked last, or the 1024th sample, ends the block; req_stall
// then stays high while one shared subtract unit and one shared multiplier run the
// block math: a restoring divide (sum*65536/count), a square root, a leading-one
// normalization, 16 squaring steps for the log2 fraction, the gain, scale and finish
// states for scaling, rounding and saturation, and a done state that holds the result
// until the output register takes it. A silent block skips the log and scaling. The
// result (RMS in Q16.8, loudness in signed Q8.8, silent flag) sits in an output
// register, and the next block's samples are taken while it waits; if rsp_stall still
// holds it there when the next result is ready, req_stall stays high until it leaves.
// The user must write registers db_gain and db_offset through the csr port only while
// the meter is idle; the block itself does not enforce this.
module audio_block_rms_db_meter_core
   import abrm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_last,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [RMS_W-1:0]           rsp_rms_q8,
   output logic signed [DB_W-1:0]     rsp_loudness_db_q8,
   output logic                       rsp_silent,
   input  logic                       csr_write,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_W-1:0]           csr_wdata
);

   logic [CSR_W-1:0] gain_ff, offset_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   res_type          rsp_ff;
   logic             accept, start, busy, res_valid, res_taken;
   blk_type          blk;
   res_type          res;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= DB_GAIN_RESET;
         offset_ff <= DB_OFFSET_RESET;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_DB_GAIN:   gain_ff   <= csr_wdata;
            CSR_DB_OFFSET: offset_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   abrm_accum u_accum (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .sample (req_sample),
      .last   (req_last),
      .start  (start),
      .blk    (blk)
   );

   abrm_post u_post (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .blk       (blk),
      .db_gain   (gain_ff),
      .db_offset (offset_ff),
      .res_taken (res_taken),
      .busy      (busy),
      .res_valid (res_valid),
      .res       (res)
   );

   // Output register: loads when empty or its transfer completes
   assign res_taken = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_taken) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_taken) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_rms_q8         = rsp_ff.rms;
   assign rsp_loudness_db_q8 = rsp_ff.db;
   assign rsp_silent         = rsp_ff.silent;

endmodule

FILE: design/abrm_accum.sv
module abrm_accum
   import abrm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  logic                       last,
   output logic                       start,
   output blk_type                    blk
);

   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [SAMPLE_W-1:0] mag;
   logic [31:0]         sq;
   logic [SUM_W-1:0]    sum_new;
   logic [COUNT_W-1:0]  count_new;
   logic                block_end;

   // Magnitude and square; the most negative sample maps to 0x8000
   assign mag       = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;
   assign sq        = mag * mag;
   assign sum_new   = sum_ff + {{(SUM_W-32){1'b0}}, sq};
   assign count_new = count_ff + 1'b1;
   assign block_end = last || (count_new == COUNT_W'(MAX_BLOCK));

   assign start     = accept && block_end;
   assign blk.sum   = sum_new;
   assign blk.count = count_new;

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (accept) begin
         if (block_end) begin
            sum_in   = '0;
            count_in = '0;
         end else begin
            sum_in   = sum_new;
            count_in = count_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: design/abrm_post.sv
module abrm_post
   import abrm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  blk_type           blk,
   input  logic [CSR_W-1:0]  db_gain,
   input  logic [CSR_W-1:0]  db_offset,
   input  logic              res_taken,
   output logic              busy,
   output logic              res_valid,
   output res_type           res
);

   state_type state_ff, state_in;

   logic [WORK_W-1:0]  work_ff, work_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [RMS_W-1:0]   root_ff, root_in;
   logic [RMS_W-1:0]   x_ff, x_in;
   logic [4:0]         e_ff, e_in;
   logic [MANT_W-1:0]  m_ff, m_in;
   logic [FRAC_W-1:0]  frac_ff, frac_in;
   logic [31:0]        t_ff, t_in;
   logic signed [V_W-1:0] v_ff, v_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   res_type            res_ff, res_in;

   // Shared subtractor
   logic [SUB_W-2:0] sub_a, sub_b;
   logic [SUB_W-1:0] sub_d;
   logic             sub_ge;
   // Shared multiplier
   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [2*MUL_W-1:0] mul_p;

   logic [11:0]            div_rem;
   logic [SUB_W-2:0]       sq_rem;
   logic [31:0]            m_sq;
   logic signed [LOG_W-1:0] log_q16;
   logic signed [V_W:0]    v_rnd;
   logic signed [23:0]     v_int;
   logic signed [24:0]     db_full;
   logic signed [DB_W-1:0] db_sat;

   assign div_rem = {rem_ff[10:0], work_ff[WORK_W-1]};
   assign sq_rem  = {rem_ff, work_ff[47:46]};
   assign log_q16 = {6'(e_ff) - 6'd8, frac_ff};

   // Operand select for the shared subtractor
   always_comb begin
      if (state_ff == ST_DIV) begin
         sub_a = {{(SUB_W-13){1'b0}}, div_rem};
         sub_b = {{(SUB_W-1-COUNT_W){1'b0}}, count_ff};
      end else begin
         sub_a = sq_rem;
         sub_b = {1'b0, root_ff, 2'b01};
      end
      sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
      sub_ge = !sub_d[SUB_W-1];
   end

   // Operand select for the shared multiplier
   always_comb begin
      unique case (state_ff)
         ST_GAIN: begin
            mul_a = {17'b0, db_gain};
            mul_b = {17'b0, LN2_Q16};
         end
         ST_SCALE: begin
            mul_a = {1'b0, t_ff};
            mul_b = MUL_W'(log_q16);
         end
         default: begin
            mul_a = {2'b0, m_ff};
            mul_b = {2'b0, m_ff};
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   assign m_sq = mul_p[61:30];

   // Rounding, offset and saturation of the loudness
   always_comb begin
      v_rnd   = (V_W+1)'(v_ff) + (V_W+1)'(64'sd2147483648);
      v_int   = v_rnd[V_W:32];
      db_full = 25'(v_int) + 25'($signed(db_offset));
      if (db_full > 25'sd32767) begin
         db_sat = 16'sd32767;
      end else if (db_full < -25'sd32768) begin
         db_sat = -16'sd32768;
      end else begin
         db_sat = db_full[DB_W-1:0];
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (start) state_in = ST_DIV;
         ST_DIV:    if (step_ff == '0) state_in = ST_SQRT;
         ST_SQRT:   if (step_ff == '0) state_in = ST_NORM;
         ST_NORM: begin
            if (x_ff == '0) begin
               state_in = ST_DONE;
            end else if (x_ff[RMS_W-1]) begin
               state_in = ST_LOGSQ;
            end
         end
         ST_LOGSQ:  if (step_ff == '0) state_in = ST_GAIN;
         ST_GAIN:   state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_FINISH;
         ST_FINISH: state_in = ST_DONE;
         ST_DONE:   if (res_taken) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath updates
   always_comb begin
      work_in  = work_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      root_in  = root_ff;
      x_in     = x_ff;
      e_in     = e_ff;
      m_in     = m_ff;
      frac_in  = frac_ff;
      t_in     = t_ff;
      v_in     = v_ff;
      step_in  = step_ff;
      res_in   = res_ff;
      unique case (state_ff)
         ST_IDLE: begin
            work_in  = {blk.sum, 16'b0};
            count_in = blk.count;
            rem_in   = '0;
            root_in  = '0;
            step_in  = STEP_W'(WORK_W - 1);
         end
         ST_DIV: begin
            // One quotient bit per cycle
            if (sub_ge) begin
               rem_in  = REM_W'(sub_d[10:0]);
               work_in = {work_ff[WORK_W-2:0], 1'b1};
            end else begin
               rem_in  = REM_W'(div_rem[10:0]);
               work_in = {work_ff[WORK_W-2:0], 1'b0};
            end
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               rem_in  = '0;
               step_in = STEP_W'(RMS_W - 1);
            end
         end
         ST_SQRT: begin
            // One root bit per cycle from a pair of radicand bits
            if (sub_ge) begin
               rem_in  = sub_d[REM_W-1:0];
               root_in = {root_ff[RMS_W-2:0], 1'b1};
            end else begin
               rem_in  = sq_rem[REM_W-1:0];
               root_in = {root_ff[RMS_W-2:0], 1'b0};
            end
            work_in = {work_ff[WORK_W-3:0], 2'b00};
            step_in = step_ff - 1'b1;
            x_in    = root_in;
            e_in    = 5'(RMS_W - 1);
         end
         ST_NORM: begin
            if (x_ff == '0) begin
               res_in.rms    = '0;
               res_in.db     = -16'sd32768;
               res_in.silent = 1'b1;
            end else if (x_ff[RMS_W-1]) begin
               m_in    = {x_ff, 7'b0};
               frac_in = '0;
               step_in = STEP_W'(FRAC_W - 1);
            end else begin
               x_in = {x_ff[RMS_W-2:0], 1'b0};
               e_in = e_ff - 1'b1;
            end
         end
         ST_LOGSQ: begin
            // One fraction bit of log2 per squaring
            if (m_sq[31]) begin
               m_in    = m_sq[31:1];
               frac_in = {frac_ff[FRAC_W-2:0], 1'b1};
            end else begin
               m_in    = m_sq[30:0];
               frac_in = {frac_ff[FRAC_W-2:0], 1'b0};
            end
            step_in = step_ff - 1'b1;
         end
         ST_GAIN:  t_in = mul_p[31:0];
         ST_SCALE: v_in = mul_p[V_W-1:0];
         ST_FINISH: begin
            res_in.rms    = root_ff;
            res_in.db     = db_sat;
            res_in.silent = 1'b0;
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      rem_ff   <= rem_in;
      count_ff <= count_in;
      root_ff  <= root_in;
      x_ff     <= x_in;
      e_ff     <= e_in;
      m_ff     <= m_in;
      frac_ff  <= frac_in;
      t_ff     <= t_in;
      v_ff     <= v_in;
      step_ff  <= step_in;
      res_ff   <= res_in;
   end

   // Outputs
   always_comb begin
      busy      = (state_ff != ST_IDLE);
      res_valid = (state_ff == ST_DONE);
      res       = res_ff;
   end

`include "audio_block_rms_db_meter_core_assert.svh"

   `ABRM_ASSERT(a_div_rem_below_count, (state_ff != ST_DIV) || (rem_ff < REM_W'(count_ff)))
   `ABRM_ASSERT(a_log_mant_normal, (state_ff != ST_LOGSQ) || m_ff[MANT_W-1])
   `ABRM_ASSERT_NEXT(a_start_enters_div, start && (state_ff == ST_IDLE), state_ff == ST_DIV)
   `ABRM_ASSERT(a_silent_zero_rms, !(res_valid && res.silent) || (res.rms == '0))

endmodule

FILE: dv/audio_block_rms_db_meter_core_tb.sv
module audio_block_rms_db_meter_core_tb;
   import abrm_pkg::*;

   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int SETTLE_CYCLES = 200;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic                       req_last;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [RMS_W-1:0]           rsp_rms_q8;
   logic signed [DB_W-1:0]     rsp_loudness_db_q8;
   logic                       rsp_silent;
   logic                       csr_write;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CSR_W-1:0]           csr_wdata;

   audio_block_rms_db_meter_core u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_rms_q8         (rsp_rms_q8),
      .rsp_loudness_db_q8 (rsp_loudness_db_q8),
      .rsp_silent         (rsp_silent),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // Meter copy kept by the testbench
   logic [15:0]        gain_q8;
   logic signed [15:0] offset_q8;
   logic [63:0]        blk_sum;
   int unsigned        blk_count;
   res_type            level_queue[$];

   bit      idle_on;
   int      errors;
   longint  cycles;
   int      stall_left;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Block math: mean square, integer root, log2 by squaring, dB scaling
   function automatic res_type block_level(input logic [63:0] sum, input int unsigned cnt);
      logic [63:0]        ms;
      logic [63:0]        root;
      logic [63:0]        bitv;
      logic [63:0]        m;
      logic [23:0]        rms;
      int                 e;
      int                 frac;
      logic signed [63:0] lg;
      logic signed [63:0] lnv;
      logic signed [63:0] v;
      logic signed [63:0] db;
      res_type            r;
      ms = (sum << 16) / cnt;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > ms) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (ms >= root + bitv) begin
            ms = ms - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      rms = root[23:0];
      if (rms == 0) begin
         r.rms = '0;
         r.db = 16'sh8000;
         r.silent = 1'b1;
         return r;
      end
      e = 0;
      while (e < 31 && (rms >> (e + 1)) != 0) e++;
      m = 64'(rms) << (30 - e);
      frac = 0;
      for (int i = 15; i >= 0; i--) begin
         m = (m * m) >> 30;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            frac = frac | (1 << i);
         end
      end
      lg = (e - 8) * 65536 + frac;
      lnv = lg * 64'sd45426;
      v = $signed({48'd0, gain_q8}) * lnv;
      db = ((v + 64'sd2147483648) >>> 32) + 64'(offset_q8);
      if (db > 32767) db = 32767;
      if (db < -32768) db = -32768;
      r.rms = rms;
      r.db = db[15:0];
      r.silent = 1'b0;
      return r;
   endfunction

   // Result check
   always @(posedge clock) begin
      res_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (level_queue.size() == 0) begin
            $display("%0t: unexpected result rms=%0d db=%0d silent=%0d", $time,
                     rsp_rms_q8, rsp_loudness_db_q8, rsp_silent);
            errors++;
         end else begin
            want = level_queue.pop_front();
            if (rsp_rms_q8 !== want.rms) begin
               $display("%0t: rms_q8 expected %0d actual %0d", $time, want.rms, rsp_rms_q8);
               errors++;
            end
            if (rsp_loudness_db_q8 !== want.db) begin
               $display("%0t: loudness_db_q8 expected %0d actual %0d", $time,
                        want.db, rsp_loudness_db_q8);
               errors++;
            end
            if (rsp_silent !== want.silent) begin
               $display("%0t: silent expected %0d actual %0d", $time, want.silent, rsp_silent);
               errors++;
            end
         end
      end
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      int r;
      if (reset || !idle_on) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            rsp_stall <= 1'b0;
         end else if (r < 93) begin
            rsp_stall <= 1'b1;
            stall_left <= $urandom_range(0, 3);
         end else begin
            rsp_stall <= 1'b1;
            stall_left <= $urandom_range(10, 60);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("audio_block_rms_db_meter_core_tb: FAIL");
         $finish;
      end
   end

   // One sample transfer, then a random gap while idle_on is set
   task automatic send_sample(input logic signed [15:0] s, input logic lst);
      int unsigned mag;
      int          gap;
      int          r;
      req_sample <= s;
      req_last <= lst;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      mag = (s < 0) ? -int'(s) : int'(s);
      blk_sum = blk_sum + 64'(mag * mag);
      blk_count++;
      if (lst || blk_count >= MAX_BLOCK) begin
         level_queue.push_back(block_level(blk_sum, blk_count));
         blk_sum = 0;
         blk_count = 0;
      end
      gap = 0;
      if (idle_on) begin
         r = $urandom_range(0, 99);
         if (r >= 90) gap = $urandom_range(10, 40);
         else if (r >= 60) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (level_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Drives one register write; the caller drops csr_write afterwards
   task automatic write_csr(input csr_index_type idx, input logic [15:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == CSR_DB_GAIN) gain_q8 = val;
      else offset_q8 = val;
   endtask

   task automatic set_scale(input logic [15:0] g, input logic [15:0] o);
      write_csr(CSR_DB_GAIN, g);
      write_csr(CSR_DB_OFFSET, o);
      csr_write <= 1'b0;
   endtask

   // Full-scale, zero and sub-unity RMS blocks, then one two-sample block
   task automatic test_extremes();
      send_sample(-16'sd32768, 1'b1);
      send_sample(16'sd32767, 1'b1);
      send_sample(16'sd0, 1'b1);
      send_sample(-16'sd1, 1'b1);
      send_sample(16'sd1, 1'b0);
      for (int i = 0; i < 14; i++) send_sample(16'sd0, 1'b0);
      send_sample(16'sd0, 1'b1);
      send_sample(16'sh5555, 1'b0);
      send_sample(16'shAAAA, 1'b1);
      drain();
   endtask

   // Block ends by length alone
   task automatic test_block_limit();
      for (int i = 0; i < MAX_BLOCK; i++)
         send_sample($signed(16'($urandom)) >>> $urandom_range(0, 15), 1'b0);
      send_sample(16'sd100, 1'b1);
      drain();
   endtask

   // Loudness clipped at both ends, then zero gain and offset
   task automatic test_saturation();
      set_scale(16'hFFFF, 16'h7FFF);
      send_sample(16'sd32767, 1'b1);
      drain();
      set_scale(16'hFFFF, 16'h8000);
      send_sample(16'sd1, 1'b0);
      for (int i = 0; i < 15; i++) send_sample(16'sd0, 1'b0);
      send_sample(16'sd0, 1'b1);
      drain();
      set_scale(16'd0, 16'd0);
      send_sample(-16'sd12345, 1'b1);
      drain();
   endtask

   // Random blocks under several gain/offset settings
   task automatic test_random_blocks();
      logic [15:0] gains[6] = '{DB_GAIN_RESET, 16'd0, 16'hFFFF, 16'd256, 16'd2151, 16'd1000};
      logic [15:0] offs[6] = '{DB_OFFSET_RESET, 16'h8000, 16'h7FFF, 16'd0, 16'hF000, 16'd5347};
      int len;
      int shift;
      for (int ph = 0; ph < 6; ph++) begin
         set_scale(gains[ph], offs[ph]);
         idle_on = (ph != 3);
         for (int n = 0; n < 110; ) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 24);
            shift = $urandom_range(0, 15);
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(0, 19) == 0)
                  send_sample(16'sd0, k == len - 1);
               else
                  send_sample($signed(16'($urandom)) >>> shift, k == len - 1);
            end
            n += len;
         end
         drain();
      end
      idle_on = 1'b1;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample = '0;
      req_last = 1'b0;
      csr_write = 1'b0;
      csr_index = CSR_DB_GAIN;
      csr_wdata = '0;
      gain_q8 = DB_GAIN_RESET;
      offset_q8 = DB_OFFSET_RESET;
      blk_sum = 0;
      blk_count = 0;
      errors = 0;
      cycles = 0;
      idle_on = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_block_limit();
      test_saturation();
      test_random_blocks();
      drain();
      if (errors == 0) begin
         $display("audio_block_rms_db_meter_core_tb: PASS");
      end else begin
         $display("audio_block_rms_db_meter_core_tb: FAIL");
      end
      $finish;
   end

endmodule
